// ----- hw/rtl/rtc_pkg.sv -----
// rtc_pkg: shared widths, register codes, configuration struct and constant functions
// for the RGB transfer curve. Depends on nothing; every file but rtc_divider imports it.
package rtc_pkg;

   localparam int WF            = 30;
   localparam int FRAC_BITS_DEF = 20;
   localparam int M_W           = 32;
   localparam int A_W           = 30;
   localparam int Q1_W          = 42;
   localparam int LMAG_W        = 35;
   localparam int SQ_STEPS      = 30;
   localparam int SC_NW         = 49;
   localparam int SC_QW         = 48;
   localparam int Y_W           = 49;
   localparam int POW_W         = 33;
   localparam int RES_W         = 43;
   localparam int CSR_DATA_W    = 20;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [13:0] GAMMA_RESET     = 14'd9830;
   localparam logic [19:0] OFFSET_RESET    = 20'd57672;
   localparam logic [19:0] KNEE_ENC_RESET  = 20'd42415;
   localparam logic [19:0] KNEE_LIN_RESET  = 20'd3283;
   localparam logic [15:0] SLOPE_RESET     = 16'd13230;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DIRECTION = 3'd0,
      REG_GAMMA     = 3'd1,
      REG_OFFSET    = 3'd2,
      REG_KNEE_ENC  = 3'd3,
      REG_KNEE_LIN  = 3'd4,
      REG_SLOPE     = 3'd5
   } rtc_reg_type;

   typedef struct packed {
      logic        direction;
      logic [13:0] gamma;
      logic [19:0] offset;
      logic [19:0] knee_enc;
      logic [19:0] knee_lin;
      logic [15:0] slope;
   } rtc_cfg_type;

   function automatic logic [63:0] isqrt64(logic [63:0] v);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] bit_v;
      x     = v;
      r     = '0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > x) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 0) begin
            if (x >= r + bit_v) begin
               x = x - (r + bit_v);
               r = (r >> 1) + bit_v;
            end else begin
               r = r >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return r;
   endfunction

   // 2^(2^-k) in Q.30, by repeated square roots from 2.0
   function automatic logic [30:0] exp_root(int k);
      logic [63:0] root;
      root = 64'd1 << (WF + 1);
      for (int j = 1; j <= k; j++) begin
         root = isqrt64(root << WF);
      end
      return root[30:0];
   endfunction

endpackage

// ----- hw/rtl/rtc_divider.sv -----
// rtc_divider: pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing beyond its parameters.
module rtc_divider #(
   parameter int NW = 62,
   parameter int DW = 31,
   parameter int QW = 42,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   logic          vld_ff  [QW+1];
   logic [DW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] sh_ff   [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic [SW-1:0] side_ff [QW+1];

   logic [DW:0]   cat_c  [QW];
   logic [DW:0]   diff_c [QW];
   logic          ge_c   [QW];

   always_comb begin
      for (int s = 0; s < QW; s++) begin
         cat_c[s]  = {rem_ff[s], sh_ff[s][QW-1]};
         ge_c[s]   = cat_c[s] >= {1'b0, den_ff[s]};
         diff_c[s] = cat_c[s] - {1'b0, den_ff[s]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= QW; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int s = 0; s < QW; s++) vld_ff[s+1] <= vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= DW'(in_num[NW-1:QW]);
         sh_ff[0]   <= in_num[QW-1:0];
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int s = 0; s < QW; s++) begin
            rem_ff[s+1]  <= ge_c[s] ? diff_c[s][DW-1:0] : cat_c[s][DW-1:0];
            sh_ff[s+1]   <= {sh_ff[s][QW-2:0], ge_c[s]};
            den_ff[s+1]  <= den_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quot  = sh_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

// ----- hw/rtl/rtc_log2.sv -----
// rtc_log2: pipelined base-2 logarithm in Q.30 by normalization and repeated squaring.
// Depends on rtc_pkg.
module rtc_log2 import rtc_pkg::*; #(
   parameter int SW = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [M_W-1:0]    in_b,
   input  logic [SW-1:0]     in_side,
   output logic              out_valid,
   output logic              out_neg,
   output logic [LMAG_W-1:0] out_mag,
   output logic [SW-1:0]     out_side
);

   logic [M_W-1:0] b0_ff, b1_ff;
   logic [4:0]     lead_in, lead1_ff;
   logic [SW-1:0]  side0_ff, side1_ff;
   logic           v0_ff, v1_ff;

   logic [30:0]    norm_in;
   logic [31:0]    shifted;
   logic [5:0]     exp_in;

   logic [30:0]    m_ff    [SQ_STEPS+1];
   logic [29:0]    fr_ff   [SQ_STEPS+1];
   logic [5:0]     e_ff    [SQ_STEPS+1];
   logic [SW-1:0]  side_ff [SQ_STEPS+1];
   logic           vld_ff  [SQ_STEPS+1];

   logic [61:0]    sq_c    [SQ_STEPS];
   logic [30:0]    mn_c    [SQ_STEPS];
   logic           bit_c   [SQ_STEPS];

   logic signed [35:0] l_c;
   logic [35:0]        abs_c;

   always_comb begin
      lead_in = '0;
      for (int i = 0; i < M_W; i++) begin
         if (b0_ff[i]) lead_in = 5'(i);
      end
   end

   always_comb begin
      if (lead1_ff >= 5'd30) shifted = b1_ff >> (lead1_ff - 5'd30);
      else shifted = b1_ff << (5'd30 - lead1_ff);
      norm_in = shifted[30:0];
      exp_in  = {1'b0, lead1_ff} - 6'd30;
   end

   always_comb begin
      for (int s = 0; s < SQ_STEPS; s++) begin
         sq_c[s]  = 62'(m_ff[s]) * 62'(m_ff[s]);
         bit_c[s] = sq_c[s][61];
         mn_c[s]  = bit_c[s] ? sq_c[s][61:31] : sq_c[s][60:30];
      end
      l_c   = $signed({e_ff[SQ_STEPS], fr_ff[SQ_STEPS]});
      abs_c = l_c[35] ? 36'(-l_c) : 36'(l_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         v1_ff     <= 1'b0;
         out_valid <= 1'b0;
         for (int s = 0; s <= SQ_STEPS; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         v0_ff     <= in_valid;
         v1_ff     <= v0_ff;
         vld_ff[0] <= v1_ff;
         for (int s = 0; s < SQ_STEPS; s++) vld_ff[s+1] <= vld_ff[s];
         out_valid <= vld_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b0_ff      <= in_b;
         side0_ff   <= in_side;
         b1_ff      <= b0_ff;
         lead1_ff   <= lead_in;
         side1_ff   <= side0_ff;
         m_ff[0]    <= norm_in;
         fr_ff[0]   <= '0;
         e_ff[0]    <= exp_in;
         side_ff[0] <= side1_ff;
         for (int s = 0; s < SQ_STEPS; s++) begin
            m_ff[s+1]    <= mn_c[s];
            fr_ff[s+1]   <= {fr_ff[s][28:0], bit_c[s]};
            e_ff[s+1]    <= e_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
         out_neg  <= l_c[35];
         out_mag  <= abs_c[LMAG_W-1:0];
         out_side <= side_ff[SQ_STEPS];
      end
   end

endmodule

// ----- hw/rtl/rtc_exp2.sv -----
// rtc_exp2: pipelined base-2 exponential of a signed Q.30 value, one root constant a stage.
// Depends on rtc_pkg.
module rtc_exp2 import rtc_pkg::*; #(
   parameter int SW = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [Y_W-1:0] in_y,
   input  logic                  in_zero,
   input  logic [SW-1:0]         in_side,
   output logic                  out_valid,
   output logic [POW_W-1:0]      out_p,
   output logic [SW-1:0]         out_side
);

   localparam logic [POW_W-1:0] POW_CAP = POW_W'(64'd1 << (WF + 2));

   logic [30:0]        root_c  [WF];
   logic [29:0]        f_ff    [WF+1];
   logic [30:0]        r_ff    [WF+1];
   logic signed [18:0] n_ff    [WF+1];
   logic               z_ff    [WF+1];
   logic [SW-1:0]      side_ff [WF+1];
   logic               vld_ff  [WF+1];

   logic [61:0]        prod_c  [WF];
   logic [30:0]        rn_c    [WF];

   logic signed [18:0] nf;
   logic [18:0]        negn;
   logic [30:0]        rf;
   logic [POW_W-1:0]   p_in;

   for (genvar k = 0; k < WF; k++) begin : g_root
      localparam logic [30:0] ROOT_K = exp_root(k + 1);
      assign root_c[k] = ROOT_K;
   end

   always_comb begin
      for (int s = 0; s < WF; s++) begin
         prod_c[s] = 62'(r_ff[s]) * 62'(root_c[s]);
         rn_c[s]   = f_ff[s][29] ? prod_c[s][60:30] : r_ff[s];
      end
   end

   always_comb begin
      nf   = n_ff[WF];
      negn = 19'(-nf);
      rf   = r_ff[WF];
      if (z_ff[WF]) p_in = '0;
      else if (nf >= 19'sd2) p_in = POW_CAP;
      else if (nf == 19'sd1) p_in = POW_W'({rf, 1'b0});
      else if (nf == 19'sd0) p_in = POW_W'(rf);
      else if (negn >= 19'd31) p_in = '0;
      else p_in = POW_W'(rf >> negn[4:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
         for (int s = 0; s <= WF; s++) vld_ff[s] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int s = 0; s < WF; s++) vld_ff[s+1] <= vld_ff[s];
         out_valid <= vld_ff[WF];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_ff[0]    <= in_y[29:0];
         n_ff[0]    <= in_y[Y_W-1:WF];
         r_ff[0]    <= 31'd1 << WF;
         z_ff[0]    <= in_zero;
         side_ff[0] <= in_side;
         for (int s = 0; s < WF; s++) begin
            f_ff[s+1]    <= {f_ff[s][28:0], 1'b0};
            r_ff[s+1]    <= rn_c[s];
            n_ff[s+1]    <= n_ff[s];
            z_ff[s+1]    <= z_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
         out_p    <= p_in;
         out_side <= side_ff[WF];
      end
   end

endmodule

// ----- hw/rtl/rtc_lane.sv -----
// rtc_lane: one channel of the transfer curve, from input magnitude to saturated result.
// Depends on rtc_pkg, rtc_divider, rtc_log2 and rtc_exp2.
module rtc_lane import rtc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  rtc_cfg_type                 cfg,
   input  logic                        in_valid,
   input  logic signed [FRAC_BITS+1:0] in_x,
   output logic                        out_valid,
   output logic signed [FRAC_BITS+1:0] out_y,
   output logic                        out_sat
);

   localparam int IO_W  = FRAC_BITS + 2;
   localparam int SHIFT = WF - FRAC_BITS;
   localparam int S1_W  = M_W + 2;
   localparam int S4_W  = S1_W + Q1_W;
   localparam int S2_W  = S4_W + 1;
   localparam int S3_W  = S2_W + 1;
   localparam logic [RES_W-1:0] HI_MAG = RES_W'((64'd1 << (IO_W - 1)) - 1);
   localparam logic [RES_W-1:0] LO_MAG = RES_W'(64'd1 << (IO_W - 1));

   logic [IO_W-1:0]   mag_in;
   logic [M_W-1:0]    m_ff;
   logic              neg_ff, va_ff;
   logic [A_W-1:0]    a_q;
   logic              pw_in;
   logic [M_W-1:0]    sum_in;
   logic [61:0]       num_in;
   logic [30:0]       den_in;

   logic              d1_valid;
   logic [Q1_W-1:0]   q1;
   logic [S1_W-1:0]   side1;
   logic [M_W-1:0]    b_in;

   logic              lg_valid, lg_neg;
   logic [LMAG_W-1:0] lg_mag;
   logic [S2_W-1:0]   lg_side;
   logic [SC_NW-1:0]  sc_num;
   logic [13:0]       sc_den;

   logic              sc_valid;
   logic [SC_QW-1:0]  qs;
   logic [S3_W-1:0]   sc_side;
   logic [Y_W-1:0]    y_in;

   logic              ex_valid;
   logic [POW_W-1:0]  p4;
   logic [S4_W-1:0]   side4;
   logic              pw4;
   logic [POW_W-1:0]  opa;
   logic [30:0]       opb;
   logic [63:0]       mul_in;

   logic [63:0]       mul_ff;
   logic [POW_W-1:0]  p_ff;
   logic [Q1_W-1:0]   q_ff;
   logic              pw_ff, negd_ff, vd_ff;

   logic signed [RES_W-1:0] r_in, r_ff;
   logic              nege_ff, ve_ff;

   logic [RES_W-1:0]  rmag;
   logic [RES_W-1:0]  vmag;
   logic              sgn;
   logic [IO_W-1:0]   y_in2;
   logic              sat_in;

   assign mag_in = in_x[IO_W-1] ? IO_W'(~in_x + 1'b1) : IO_W'(in_x);
   assign a_q    = {cfg.offset, 10'b0};

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (en) va_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff   <= {mag_in, {SHIFT{1'b0}}};
         neg_ff <= in_x[IO_W-1];
      end
   end

   always_comb begin
      if (cfg.direction) pw_in = m_ff > M_W'({cfg.knee_lin, 10'b0});
      else pw_in = m_ff > M_W'({cfg.knee_enc, 10'b0});
      sum_in = m_ff + M_W'(a_q);
      if (pw_in) begin
         num_in = {sum_in, 30'b0};
         den_in = {1'b1, a_q};
      end else begin
         num_in = 62'({m_ff, 10'b0});
         den_in = (cfg.slope == '0) ? 31'd1 : 31'(cfg.slope);
      end
   end

   rtc_divider #(.NW(62), .DW(31), .QW(Q1_W), .SW(S1_W)) u_front_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (va_ff),
      .in_num   (num_in),
      .in_den   (den_in),
      .in_side  ({pw_in, neg_ff, m_ff}),
      .out_valid(d1_valid),
      .out_quot (q1),
      .out_side (side1)
   );

   assign b_in = cfg.direction ? side1[M_W-1:0] : q1[M_W-1:0];

   rtc_log2 #(.SW(S2_W)) u_log2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (d1_valid),
      .in_b     (b_in),
      .in_side  ({b_in == '0, side1, q1}),
      .out_valid(lg_valid),
      .out_neg  (lg_neg),
      .out_mag  (lg_mag),
      .out_side (lg_side)
   );

   always_comb begin
      if (cfg.direction) begin
         sc_num = SC_NW'(lg_mag) * SC_NW'(13'd4096);
         sc_den = (cfg.gamma == '0) ? 14'd1 : cfg.gamma;
      end else begin
         sc_num = SC_NW'(lg_mag) * SC_NW'(cfg.gamma);
         sc_den = 14'd4096;
      end
   end

   rtc_divider #(.NW(SC_NW), .DW(14), .QW(SC_QW), .SW(S3_W)) u_scale_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (lg_valid),
      .in_num   (sc_num),
      .in_den   (sc_den),
      .in_side  ({lg_neg, lg_side}),
      .out_valid(sc_valid),
      .out_quot (qs),
      .out_side (sc_side)
   );

   assign y_in = sc_side[S3_W-1] ? Y_W'(-{1'b0, qs}) : Y_W'({1'b0, qs});

   rtc_exp2 #(.SW(S4_W)) u_exp2 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sc_valid),
      .in_y     (y_in),
      .in_zero  (sc_side[S4_W]),
      .in_side  (sc_side[S4_W-1:0]),
      .out_valid(ex_valid),
      .out_p    (p4),
      .out_side (side4)
   );

   assign pw4    = side4[S4_W-1];
   assign opa    = pw4 ? p4 : POW_W'(side4[Q1_W+M_W-1:Q1_W]);
   assign opb    = pw4 ? {1'b1, a_q} : 31'(cfg.slope);
   assign mul_in = 64'(opa) * 64'(opb);

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff     <= 1'b0;
         ve_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else if (en) begin
         vd_ff     <= ex_valid;
         ve_ff     <= vd_ff;
         out_valid <= ve_ff;
      end
   end

   always_comb begin
      case ({cfg.direction, pw_ff})
         2'b11:   r_in = $signed(RES_W'(mul_ff[63:30])) - $signed(RES_W'(a_q));
         2'b10:   r_in = $signed(RES_W'(mul_ff[47:10]));
         2'b01:   r_in = $signed(RES_W'(p_ff));
         default: r_in = $signed(RES_W'(q_ff));
      endcase
   end

   always_comb begin
      rmag = r_ff[RES_W-1] ? RES_W'(-r_ff) : RES_W'(r_ff);
      vmag = rmag >> SHIFT;
      sgn  = r_ff[RES_W-1] ^ nege_ff;
      sat_in = 1'b0;
      if (!sgn) begin
         if (vmag > HI_MAG) begin
            y_in2  = HI_MAG[IO_W-1:0];
            sat_in = 1'b1;
         end else begin
            y_in2 = vmag[IO_W-1:0];
         end
      end else begin
         if (vmag > LO_MAG) begin
            y_in2  = LO_MAG[IO_W-1:0];
            sat_in = 1'b1;
         end else begin
            y_in2 = IO_W'(-vmag[IO_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_ff  <= mul_in;
         p_ff    <= p4;
         q_ff    <= side4[Q1_W-1:0];
         pw_ff   <= pw4;
         negd_ff <= side4[S4_W-2];
         r_ff    <= r_in;
         nege_ff <= negd_ff;
         out_y   <= $signed(y_in2);
         out_sat <= sat_in;
      end
   end

endmodule

// ----- hw/rtl/rgb_transfer_curve.sv -----
// rgb_transfer_curve: three-lane sRGB-style transfer curve on one pixel per transfer.
// Throughput one pixel per cycle while the output is not stalled. Each lane holds two
// restoring dividers (42 and 48 bit stages) and the 30-step logarithm and exponential
// pipelines; a stalled output holds the whole pipe.
// Synchronous active-high reset clears valid state and loads the register defaults.
// Depends on rtc_pkg and rtc_lane.
module rgb_transfer_curve import rtc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [FRAC_BITS+1:0]  req_in_red,
   input  logic signed [FRAC_BITS+1:0]  req_in_green,
   input  logic signed [FRAC_BITS+1:0]  req_in_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [FRAC_BITS+1:0]  rsp_out_red,
   output logic signed [FRAC_BITS+1:0]  rsp_out_green,
   output logic signed [FRAC_BITS+1:0]  rsp_out_blue,
   output logic                         rsp_saturated,
   input  logic                         csr_write_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int IO_W = FRAC_BITS + 2;

   rtc_cfg_type             cfg_ff;
   logic                    adv;
   logic                    rsp_valid_ff;
   logic signed [IO_W-1:0]  lane_x     [3];
   logic                    lane_valid [3];
   logic signed [IO_W-1:0]  lane_y     [3];
   logic                    lane_sat   [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction <= 1'b0;
         cfg_ff.gamma     <= GAMMA_RESET;
         cfg_ff.offset    <= OFFSET_RESET;
         cfg_ff.knee_enc  <= KNEE_ENC_RESET;
         cfg_ff.knee_lin  <= KNEE_LIN_RESET;
         cfg_ff.slope     <= SLOPE_RESET;
      end else if (csr_write_en) begin
         case (rtc_reg_type'(csr_index))
            REG_DIRECTION: cfg_ff.direction <= csr_data[0];
            REG_GAMMA:     cfg_ff.gamma     <= csr_data[13:0];
            REG_OFFSET:    cfg_ff.offset    <= csr_data;
            REG_KNEE_ENC:  cfg_ff.knee_enc  <= csr_data;
            REG_KNEE_LIN:  cfg_ff.knee_lin  <= csr_data;
            REG_SLOPE:     cfg_ff.slope     <= csr_data[15:0];
            default:       ;
         endcase
      end
   end

   // advance the whole pipe unless a finished result is held
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign lane_x[0] = req_in_red;
   assign lane_x[1] = req_in_green;
   assign lane_x[2] = req_in_blue;

   for (genvar i = 0; i < 3; i++) begin : g_lane
      rtc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .cfg      (cfg_ff),
         .in_valid (req_valid),
         .in_x     (lane_x[i]),
         .out_valid(lane_valid[i]),
         .out_y    (lane_y[i]),
         .out_sat  (lane_sat[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= lane_valid[0] & lane_valid[1] & lane_valid[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_out_red   <= lane_y[0];
         rsp_out_green <= lane_y[1];
         rsp_out_blue  <= lane_y[2];
         rsp_saturated <= lane_sat[0] | lane_sat[1] | lane_sat[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking bench for rgb_transfer_curve, one pixel per transfer on valid/ready.
// Holds its own fixed-point model of the transfer curve, walks a directed table, then
// random pixels under several register settings. Depends on rtc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
   import rtc_pkg::*;

   localparam int                 CW       = 22;
   localparam int                 LATENCY  = 170;
   localparam int                 PHASES   = 9;
   localparam int                 PER_PASS = 222;
   localparam longint unsigned    ONE_Q    = 64'd1 << 30;
   localparam logic signed [21:0] CH_MAX   = 22'sh1FFFFF;
   localparam logic signed [21:0] CH_MIN   = -22'sd2097152;
   localparam logic [2:0]         REG_UNUSED = 3'd7;
   localparam logic [1:0]         CHK_DIR0 = 2'd0;
   localparam logic [1:0]         CHK_ANY  = 2'd2;
   localparam logic [1:0]         CHK_NONE = 2'd3;

   typedef struct packed {
      logic signed [21:0] red;
      logic signed [21:0] green;
      logic signed [21:0] blue;
      logic               sat;
   } pixel_type;

   typedef struct packed {
      logic [1:0] chk;
      pixel_type  px;
      pixel_type  want;
   } curve_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic signed [21:0]  req_in_red = '0;
   logic signed [21:0]  req_in_green = '0;
   logic signed [21:0]  req_in_blue = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [21:0]  rsp_out_red;
   logic signed [21:0]  rsp_out_green;
   logic signed [21:0]  rsp_out_blue;
   logic                rsp_saturated;
   logic                csr_write_en = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [19:0]         csr_data = '0;

   rtc_cfg_type     curve_cfg;
   longint unsigned root_tab [1:30];
   pixel_type       pending_pixels [$];
   int              idle_mode = 0;
   int              mismatches = 0;

   curve_row_type curve_rows [] = '{
      '{CHK_ANY,  '{22'sd0, 22'sd0, 22'sd0, 1'b0}, '{22'sd0, 22'sd0, 22'sd0, 1'b0}},
      '{CHK_DIR0, '{CH_MAX, CH_MAX, CH_MAX, 1'b0}, '{CH_MAX, CH_MAX, CH_MAX, 1'b1}},
      '{CHK_DIR0, '{CH_MIN, CH_MIN, CH_MIN, 1'b0}, '{CH_MIN, CH_MIN, CH_MIN, 1'b1}},
      '{CHK_NONE, '{22'sd42415, -22'sd42415, 22'sd42416, 1'b0}, '0},
      '{CHK_NONE, '{22'sd3283, -22'sd3283, 22'sd3284, 1'b0}, '0},
      '{CHK_NONE, '{22'sd1, -22'sd1, 22'sd2, 1'b0}, '0},
      '{CHK_NONE, '{22'sd1048576, -22'sd1048576, 22'sd524288, 1'b0}, '0},
      '{CHK_NONE, '{CH_MAX, 22'sd0, CH_MIN, 1'b0}, '0},
      '{CHK_NONE, '{-22'sd3284, 22'sd42414, 22'sd100000, 1'b0}, '0},
      '{CHK_NONE, '{22'sd1048575, -22'sd1048577, -22'sd42416, 1'b0}, '0},
      '{CHK_NONE, '{-22'sd2, 22'sd3282, CH_MAX, 1'b0}, '0}
   };

   rgb_transfer_curve u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_saturated (rsp_saturated),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned x, r, b;
      x = v;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint log2_fix(longint unsigned b);
      int              p;
      longint unsigned m, frac;
      p = 63;
      frac = 0;
      while (p > 0 && b[p] == 1'b0) p--;
      m = (p >= 30) ? (b >> (p - 30)) : (b << (30 - p));
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (ONE_Q << 1)) begin
            m = m >> 1;
            frac = frac | (64'd1 << i);
         end
      end
      return longint'(p - 30) * longint'(ONE_Q) + longint'(frac);
   endfunction

   function automatic longint unsigned exp2_fix(longint y);
      longint unsigned f, r;
      longint          n;
      f = longint'(y) & (ONE_Q - 1);
      n = (y - longint'(f)) / longint'(ONE_Q);
      r = ONE_Q;
      for (int k = 1; k <= 30; k++) begin
         if (f[30 - k]) r = (r * root_tab[k]) >> 30;
      end
      if (n >= 2) return ONE_Q << 2;
      if (n >= 0) return r << n;
      if (-n >= 63) return 0;
      return r >> (-n);
   endfunction

   function automatic longint unsigned power_fix(longint unsigned b, longint unsigned num,
                                                 longint unsigned den);
      longint          l;
      longint unsigned mag;
      if (b == 0) return 0;
      l = log2_fix(b);
      mag = (l < 0) ? longint'(-l) : longint'(l);
      mag = (mag * num) / den;
      return exp2_fix(l < 0 ? -longint'(mag) : longint'(mag));
   endfunction

   function automatic longint transfer_mag(longint unsigned m);
      longint unsigned a, phi, g, base, p;
      a = longint'(curve_cfg.offset) << 10;
      phi = (curve_cfg.slope != 0) ? longint'(curve_cfg.slope) : 1;
      if (curve_cfg.direction == 1'b0) begin
         if (m > (longint'(curve_cfg.knee_enc) << 10)) begin
            base = ((m + a) << 30) / (ONE_Q + a);
            return longint'(power_fix(base, longint'(curve_cfg.gamma), 4096));
         end
         return longint'((m << 10) / phi);
      end
      if (m > (longint'(curve_cfg.knee_lin) << 10)) begin
         g = (curve_cfg.gamma != 0) ? longint'(curve_cfg.gamma) : 1;
         p = power_fix(m, 4096, g);
         return longint'(((ONE_Q + a) * p) >> 30) - longint'(a);
      end
      return longint'((m * longint'(curve_cfg.slope)) >> 10);
   endfunction

   function automatic logic signed [21:0] transfer_channel(logic signed [21:0] x,
                                                          inout logic sat);
      logic [21:0]     v;
      longint unsigned mag;
      longint          r, q;
      v = x;
      mag = v[21] ? ((64'd1 << CW) - longint'(v)) : longint'(v);
      r = transfer_mag(mag << 10);
      q = (r >= 0) ? longint'(longint'(r) >> 10) : -longint'(longint'(-r) >> 10);
      if (v[21]) q = -q;
      if (q > longint'(CH_MAX)) begin
         q = longint'(CH_MAX);
         sat = 1'b1;
      end
      if (q < longint'(CH_MIN)) begin
         q = longint'(CH_MIN);
         sat = 1'b1;
      end
      return q[21:0];
   endfunction

   function automatic pixel_type transfer_pixel(pixel_type px);
      pixel_type o;
      logic      sat;
      sat = 1'b0;
      o.red = transfer_channel(px.red, sat);
      o.green = transfer_channel(px.green, sat);
      o.blue = transfer_channel(px.blue, sat);
      o.sat = sat;
      return o;
   endfunction

   function automatic logic signed [21:0] random_channel();
      logic signed [21:0] v;
      case ($urandom_range(5))
         0: v = 22'($urandom_range(4095));
         1: v = 22'sd42415 + $signed(22'($urandom_range(64))) - 22'sd32;
         2: v = 22'sd3283 + $signed(22'($urandom_range(64))) - 22'sd32;
         3: v = 22'sd1048576 + $signed(22'($urandom_range(2048))) - 22'sd1024;
         4: v = $urandom_range(1) ? CH_MAX : CH_MIN;
         default: v = 22'($urandom);
      endcase
      if ($urandom_range(1)) v = -v;
      return v;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [19:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         REG_DIRECTION: curve_cfg.direction = value[0];
         REG_GAMMA:     curve_cfg.gamma = value[13:0];
         REG_OFFSET:    curve_cfg.offset = value;
         REG_KNEE_ENC:  curve_cfg.knee_enc = value;
         REG_KNEE_LIN:  curve_cfg.knee_lin = value;
         REG_SLOPE:     curve_cfg.slope = value[15:0];
         default: ;
      endcase
   endtask

   task automatic write_curve(logic dir, logic [13:0] gam, logic [19:0] off,
                              logic [19:0] kenc, logic [19:0] klin, logic [15:0] slp);
      write_reg(REG_DIRECTION, 20'(dir));
      write_reg(REG_GAMMA, 20'(gam));
      write_reg(REG_OFFSET, off);
      write_reg(REG_KNEE_ENC, kenc);
      write_reg(REG_KNEE_LIN, klin);
      write_reg(REG_SLOPE, 20'(slp));
      csr_write_en <= 1'b0;
   endtask

   task automatic send_pixel(pixel_type px, logic [1:0] chk, pixel_type want);
      while (idle_mode == 0 ? $urandom_range(99) < 17 :
             idle_mode == 1 ? $urandom_range(99) < 56 : 1'b0) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_red <= px.red;
      req_in_green <= px.green;
      req_in_blue <= px.blue;
      do @(posedge clock); while (!req_ready);
      if (chk == CHK_ANY || (chk != CHK_NONE && chk[0] == curve_cfg.direction))
         pending_pixels.push_back(want);
      else
         pending_pixels.push_back(transfer_pixel(px));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer on result channel");
            end else begin
               want = pending_pixels.pop_front();
               if (want.red !== rsp_out_red || want.green !== rsp_out_green ||
                   want.blue !== rsp_out_blue || want.sat !== rsp_saturated) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: want %0d %0d %0d sat %0b, got %0d %0d %0d sat %0b",
                              want.red, want.green, want.blue, want.sat, rsp_out_red,
                              rsp_out_green, rsp_out_blue, rsp_saturated);
               end
            end
         end
         rsp_ready <= (idle_mode == 0) ? ($urandom_range(99) >= 56) :
                      (idle_mode == 1) ? ($urandom_range(99) >= 17) : 1'b1;
      end
   end

   initial begin
      pixel_type px;
      root_tab[1] = int_sqrt((ONE_Q << 1) << 30);
      for (int k = 2; k <= 30; k++) root_tab[k] = int_sqrt(root_tab[k - 1] << 30);
      curve_cfg = '{1'b0, GAMMA_RESET, OFFSET_RESET, KNEE_ENC_RESET, KNEE_LIN_RESET,
                    SLOPE_RESET};
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_mode = ph / 3;
         if (ph != 0) drain_pipe();
         case (ph)
            1: write_curve(1'b1, GAMMA_RESET, OFFSET_RESET, KNEE_ENC_RESET, KNEE_LIN_RESET,
                           SLOPE_RESET);
            2: write_curve(1'b0, 14'($urandom_range(16383, 4097)),
                           20'($urandom_range(1048575, 1)),
                           20'($urandom_range(200000)), 20'($urandom_range(20000)),
                           16'($urandom_range(65535, 1024)));
            3: write_curve(1'b1, 14'd4097, 20'd1, 20'd0, 20'd0, 16'd1024);
            4: write_curve(1'b0, 14'd16383, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
            5: write_curve(1'b1, 14'd0, 20'($urandom_range(1048575, 1)),
                           20'($urandom_range(300000)), 20'($urandom_range(300000)),
                           16'd0);
            6: begin
               write_reg(REG_UNUSED, 20'hFFFFF);
               write_curve(1'b0, 14'd0, 20'($urandom), 20'($urandom_range(300000)),
                           20'($urandom_range(300000)), 16'd0);
            end
            7: write_curve(1'b1, 14'd16383, 20'hFFFFF, 20'd0, 20'hFFFFF, 16'hFFFF);
            8: write_curve(1'($urandom_range(1)), 14'($urandom_range(16383, 4097)),
                           20'($urandom), 20'($urandom_range(100000)),
                           20'($urandom_range(100000)),
                           16'($urandom_range(65535, 1024)));
            default: ;
         endcase
         if (ph < 2) begin
            foreach (curve_rows[i]) send_pixel(curve_rows[i].px, curve_rows[i].chk,
                                               curve_rows[i].want);
         end
         for (int n = 0; n < PER_PASS; n++) begin
            px = '{random_channel(), random_channel(), random_channel(), 1'b0};
            send_pixel(px, CHK_NONE, '0);
         end
      end
      drain_pipe();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
